/* rtl/assert_macros.svh */
// Assertion macros for the RTL files of the ROM write command receiver.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while the async reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on the next edge
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

/* rtl/rwcr_pkg.sv */
// Shared types, codes and constants for the ROM write command receiver.
// No dependencies; imported by rwcr_receiver and rom_write_command_receiver.
package rwcr_pkg;

	// Default ROM window / bank size in bytes
	localparam int unsigned BANK_BYTES_DEF = 16384;

	// Bus event kinds
	typedef enum logic [1:0] {
		MODE_WRITE  = 2'd0,
		MODE_READ   = 2'd1,
		MODE_TICK   = 2'd2,
		MODE_BUTTON = 2'd3
	} mode_t;

	// Read source codes
	typedef enum logic [1:0] {
		SRC_NORMAL   = 2'd0,
		SRC_INTERNAL = 2'd1,
		SRC_CART     = 2'd2
	} src_t;

	// Receiver state, one-hot
	typedef enum logic [4:0] {
		RX_DISABLED  = 5'b00001,
		RX_LOCKED    = 5'b00010,
		RX_WAITING   = 5'b00100,
		RX_RECEIVING = 5'b01000,
		RX_PENDING   = 5'b10000
	} rx_state_t;

	// Externally visible receiver state codes
	localparam logic [2:0] ST_CODE_DISABLED  = 3'd0;
	localparam logic [2:0] ST_CODE_LOCKED    = 3'd1;
	localparam logic [2:0] ST_CODE_WAITING   = 3'd2;
	localparam logic [2:0] ST_CODE_RECEIVING = 3'd3;
	localparam logic [2:0] ST_CODE_PENDING   = 3'd4;

	// Commands
	localparam logic [7:0] CMD_BANK_LAST  = 8'd33;
	localparam logic [7:0] CMD_LOCK_INT   = 8'd34;
	localparam logic [7:0] CMD_RESET      = 8'd36;
	localparam logic [7:0] CMD_BANK_DATA  = 8'd40;
	localparam logic [7:0] CMD_LOCK_CTRL  = 8'd46;
	localparam logic [7:0] CMD_REPEAT_LIM = 8'd40;

	// Lock command data values
	localparam logic [7:0] LOCK_ARG_LOCK    = 8'd1;
	localparam logic [7:0] LOCK_ARG_UNLOCK  = 8'd16;
	localparam logic [7:0] LOCK_ARG_DISABLE = 8'd31;

	// Bank number that maps the window to the internal ROM
	localparam logic [7:0] BANK_INTERNAL = 8'd32;

	// Execution delays in T-states
	localparam logic [6:0] DELAY_CONFIRM = 7'd35;
	localparam logic [6:0] DELAY_SMALL   = 7'd119;
	localparam logic [6:0] DELAY_LARGE   = 7'd121;

	// Window offsets of the command registers
	localparam logic [15:0] OFS_CONFIRM = 16'd0;
	localparam logic [15:0] OFS_COMMAND = 16'd1;
	localparam logic [15:0] OFS_DATA1   = 16'd2;
	localparam logic [15:0] OFS_DATA2   = 16'd3;

	// One bus event
	typedef struct packed {
		mode_t       mode;
		logic [15:0] address;
		logic [7:0]  data_byte;
		logic [7:0]  elapsed_cycles;
	} bus_item_t;

	// One result
	typedef struct packed {
		src_t        read_source;
		logic [21:0] cart_address;
		logic        reset_pulse;
		logic        nmi_pulse;
		logic [7:0]  current_bank;
		logic [2:0]  receiver_state;
	} bus_result_t;

	function automatic logic [2:0] state_code(input rx_state_t s);
		logic [2:0] c;
		unique case (s)
			RX_DISABLED:  c = ST_CODE_DISABLED;
			RX_LOCKED:    c = ST_CODE_LOCKED;
			RX_WAITING:   c = ST_CODE_WAITING;
			RX_RECEIVING: c = ST_CODE_RECEIVING;
			RX_PENDING:   c = ST_CODE_PENDING;
			default:      c = ST_CODE_DISABLED;
		endcase
		return c;
	endfunction

endpackage

/* rtl/rwcr_receiver.sv */
// Command receiver, bank register and read mapping of the ROM cartridge controller.
// Depends on rwcr_pkg. State advances on en; the result is combinational from the item.
module rwcr_receiver
	import rwcr_pkg::*;
#(
	parameter int unsigned BANK_BYTES = BANK_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        small_machine,
	input  logic        en,
	input  bus_item_t   item,
	output bus_result_t result
);

	localparam logic [16:0] WIN_LIMIT = 17'(BANK_BYTES);
	localparam logic [16:0] BANK_MULT = 17'(BANK_BYTES);

	// State registers
	rx_state_t   mode_q, mode_d;
	logic        powered_q, powered_d;
	logic [7:0]  bank_q, bank_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [7:0]  rc_q, rc_d;
	logic [7:0]  first_q, first_d;
	logic [7:0]  second_q, second_d;
	logic [6:0]  delay_q, delay_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic        las_q, las_d;

	logic        in_window;
	logic        was_locked;
	rx_state_t   rx_mid;
	logic [7:0]  cmd_mid;
	logic [7:0]  rc_inc;
	logic [16:0] elapsed_sum;
	logic [15:0] elapsed_sat;
	logic        fire;
	logic        lock_ok;
	logic [24:0] bank_base;
	src_t        src;
	logic [21:0] caddr;
	logic        rst_p;
	logic        nmi_p;

	// Address decode and helper terms
	assign in_window   = {1'b0, item.address} < WIN_LIMIT;
	assign was_locked  = (mode_q == RX_LOCKED) || ((mode_q == RX_PENDING) && las_q);
	assign rx_mid      = (mode_q == RX_WAITING) ? RX_RECEIVING : mode_q;
	assign cmd_mid     = (mode_q == RX_WAITING) ? item.data_byte : cmd_q;
	assign rc_inc      = ((mode_q == RX_WAITING) ? 8'd0 : rc_q) + 8'd1;
	assign elapsed_sum = {1'b0, elapsed_q} + {9'd0, item.elapsed_cycles};
	assign elapsed_sat = elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0];
	assign fire        = (mode_q == RX_PENDING) && (elapsed_sat > {9'd0, delay_q});
	assign lock_ok     = (first_q == second_q);
	assign bank_base   = 25'(bank_q * BANK_MULT);

	// Next state and result
	always_comb begin
		mode_d    = mode_q;
		powered_d = powered_q;
		bank_d    = bank_q;
		cmd_d     = cmd_q;
		rc_d      = rc_q;
		first_d   = first_q;
		second_d  = second_q;
		delay_d   = delay_q;
		elapsed_d = elapsed_q;
		las_d     = las_q;
		src       = SRC_NORMAL;
		caddr     = 22'd0;
		rst_p     = 1'b0;
		nmi_p     = 1'b0;

		unique case (item.mode)
			MODE_WRITE: begin
				if (powered_q && in_window && (mode_q != RX_DISABLED)) begin
					priority if (item.address == OFS_CONFIRM) begin
						las_d     = was_locked;
						delay_d   = DELAY_CONFIRM;
						elapsed_d = 16'd0;
						mode_d    = RX_PENDING;
					end else if (item.address == OFS_COMMAND) begin
						// repeated byte counts up to a one-byte command
						if (rx_mid == RX_RECEIVING) begin
							mode_d = RX_RECEIVING;
							cmd_d  = cmd_mid;
							rc_d   = rc_inc;
							if ((item.data_byte < CMD_REPEAT_LIM) && (item.data_byte == rc_inc)) begin
								las_d     = 1'b0;
								delay_d   = small_machine ? DELAY_SMALL : DELAY_LARGE;
								elapsed_d = 16'd0;
								mode_d    = RX_PENDING;
							end else if (item.data_byte != cmd_mid) begin
								rc_d  = 8'd1;
								cmd_d = item.data_byte;
							end
						end
					end else if (item.address == OFS_DATA1) begin
						first_d = item.data_byte;
					end else if (item.address == OFS_DATA2) begin
						second_d = item.data_byte;
					end else begin
						// higher offsets in the window are ignored
					end
				end
			end
			MODE_READ: begin
				if (powered_q && in_window) begin
					if (bank_q == BANK_INTERNAL) begin
						src = SRC_INTERNAL;
					end else begin
						src   = SRC_CART;
						caddr = 22'(bank_base + {9'd0, item.address});
					end
				end
			end
			MODE_TICK: begin
				elapsed_d = elapsed_sat;
				if (fire) begin
					mode_d = las_q ? RX_LOCKED : RX_WAITING;
					if (las_q) begin
						if ((cmd_q == CMD_LOCK_CTRL) && lock_ok) begin
							if (first_q == LOCK_ARG_LOCK) mode_d = RX_LOCKED;
							if (first_q == LOCK_ARG_UNLOCK) mode_d = RX_WAITING;
							if (first_q == LOCK_ARG_DISABLE) mode_d = RX_DISABLED;
						end
					end else begin
						priority if ((cmd_q != 8'd0) && (cmd_q <= CMD_BANK_LAST)) begin
							bank_d = cmd_q - 8'd1;
						end else if (cmd_q == CMD_LOCK_INT) begin
							mode_d = RX_LOCKED;
							bank_d = BANK_INTERNAL;
						end else if (cmd_q == CMD_RESET) begin
							rst_p = 1'b1;
						end else if (cmd_q == CMD_BANK_DATA) begin
							bank_d = first_q - 8'd1;
							if (second_q[3]) mode_d = RX_DISABLED;
							if (second_q[2]) mode_d = RX_LOCKED;
							nmi_p = second_q[1];
							rst_p = second_q[0];
						end else if (cmd_q == CMD_LOCK_CTRL) begin
							if (lock_ok) begin
								if (first_q == LOCK_ARG_LOCK) mode_d = RX_LOCKED;
								if (first_q == LOCK_ARG_UNLOCK) mode_d = RX_WAITING;
								if (first_q == LOCK_ARG_DISABLE) mode_d = RX_DISABLED;
							end
						end else begin
							// unknown commands have no effect
						end
					end
				end
			end
			MODE_BUTTON: begin
				powered_d = 1'b1;
				bank_d    = 8'd0;
				mode_d    = RX_WAITING;
				las_d     = 1'b0;
				rst_p     = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign result.read_source    = src;
	assign result.cart_address   = caddr;
	assign result.reset_pulse    = rst_p;
	assign result.nmi_pulse      = nmi_p;
	assign result.current_bank   = bank_d;
	assign result.receiver_state = state_code(mode_d);

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= RX_DISABLED;
			powered_q <= 1'b0;
			bank_q    <= 8'd0;
			cmd_q     <= 8'd0;
			rc_q      <= 8'd0;
			first_q   <= 8'd0;
			second_q  <= 8'd0;
			delay_q   <= 7'd0;
			elapsed_q <= 16'd0;
			las_q     <= 1'b0;
		end else if (en) begin
			mode_q    <= mode_d;
			powered_q <= powered_d;
			bank_q    <= bank_d;
			cmd_q     <= cmd_d;
			rc_q      <= rc_d;
			first_q   <= first_d;
			second_q  <= second_d;
			delay_q   <= delay_d;
			elapsed_q <= elapsed_d;
			las_q     <= las_d;
		end
	end

endmodule

/* rtl/rom_write_command_receiver.sv */
// ROM write command receiver: bank-switching cartridge controller, stream wrapper.
// Depends on rwcr_pkg, rwcr_receiver and assert_macros.svh.
//
// Takes one bus event per clock and returns one result per event, in order.
// A request is captured in an input register and evaluated against the
// receiver state once the output register can take its result; the receiver
// state is updated in the same edge that loads the output register, which
// drives m_tvalid, and the result can be taken at the next edge; throughput
// is one request per clock as long as the result side keeps taking results.
// The input and output registers decouple the two sides, so a new request is
// taken while a finished result still waits. small_machine is written through
// cfg_wen and must only change while no request is in flight.
`include "assert_macros.svh"

module rom_write_command_receiver
	import rwcr_pkg::*;
#(
	parameter int unsigned BANK_BYTES = BANK_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wen,
	input  logic [0:0]  cfg_wdata,    // small_machine
	// bus events
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,      // address[15:0], data_byte[23:16], elapsed_cycles[31:24]
	input  logic [1:0]  s_tuser,      // mode[1:0]
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,      // cart_address[21:0], reset_pulse[22], nmi_pulse[23],
	                                  // current_bank[31:24], receiver_state[34:32], zero[39:35]
	output logic [1:0]  m_tuser       // read_source[1:0]
);

	logic        small_machine_q;
	bus_item_t   in_item;
	bus_item_t   item_s1;
	logic        valid_s1;
	logic        advance;
	logic        take;
	bus_result_t res;
	bus_result_t out_q;
	logic        out_valid_q;

	// Unpack the request
	assign in_item.mode           = mode_t'(s_tuser);
	assign in_item.address        = s_tdata[15:0];
	assign in_item.data_byte      = s_tdata[23:16];
	assign in_item.elapsed_cycles = s_tdata[31:24];

	// Handshake control
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign take     = s_tvalid && s_tready;

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_machine_q <= 1'b1;
		end else if (cfg_wen) begin
			small_machine_q <= cfg_wdata[0];
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= in_item;
		end
	end

	rwcr_receiver #(
		.BANK_BYTES(BANK_BYTES)
	) u_receiver (
		.clk          (clk),
		.arst_n       (arst_n),
		.small_machine(small_machine_q),
		.en           (advance),
		.item         (item_s1),
		.result       (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.read_source;
	assign m_tdata  = {5'd0, out_q.receiver_state, out_q.current_bank, out_q.nmi_pulse,
		out_q.reset_pulse, out_q.cart_address};

	// Assertions
	`ASSERT_CLK(a_ready_when_empty, clk, arst_n, !out_valid_q |-> s_tready, "input stalled with empty output register")
	`ASSERT_NEXT(a_src_only_on_read, clk, arst_n, advance && (item_s1.mode != MODE_READ), m_tuser == SRC_NORMAL, "read source set for a non-read request")
	`ASSERT_NEXT(a_button_resets, clk, arst_n, advance && (item_s1.mode == MODE_BUTTON), m_tdata[22], "button press without reset pulse")
	`ASSERT_NEXT(a_nmi_only_on_tick, clk, arst_n, advance && (item_s1.mode != MODE_TICK), !m_tdata[23], "NMI pulse outside an instruction-end tick")

endmodule
